@@ src/npc_pkg.sv @@
// npc_pkg: shared types, constants and helpers for the nearest palette color unit.
// No dependencies; used by npc_ram and nearest_palette_color_unit.

package npc_pkg;

    localparam int PALETTE_ENTRIES = 128;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int COLOR_W         = 24;
    localparam int CH_W            = 12;
    localparam int CODE_W          = 8;
    localparam int ERR_W           = 10;   // three 8-bit differences sum to at most 765
    localparam int MAX_ERR         = 765;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [COLOR_W-1:0] data;
    } wr_req_t;

    // signed 12-bit channel clamped to 0..255
    function automatic logic [7:0] clamp_channel(input logic [CH_W-1:0] v);
        logic [7:0] res;
        if (v[CH_W-1])
            res = 8'd0;
        else if (|v[CH_W-2:8])
            res = 8'hFF;
        else
            res = v[7:0];
        return res;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] res;
        if (a > b)
            res = a - b;
        else
            res = b - a;
        return res;
    endfunction

endpackage

@@ src/nearest_palette_color_unit.sv @@
// nearest_palette_color_unit: nearest-color (L1) search over the palette RAM.
// Depends on npc_pkg and npc_ram.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall| mode, entry_index, entry_color, red/green/blue
//  out     | output    | out_valid/out_stall | color_code
//
// A palette write gives no result.
// A query reads one palette entry per cycle through the single RAM read port;
// it passes SCAN, DRAIN and FINISH and returns to IDLE before the next request.
// Reset clears the sequencer and output valid; palette contents stay undefined.
// The result sits in an output register; a stalled output holds the next query in FINISH.

module nearest_palette_color_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [6:0]                    entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]   entry_color,
    input  logic signed [npc_pkg::CH_W-1:0] red,
    input  logic signed [npc_pkg::CH_W-1:0] green,
    input  logic signed [npc_pkg::CH_W-1:0] blue,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [npc_pkg::CODE_W-1:0]    color_code
);

    localparam logic [npc_pkg::IDX_W-1:0] LAST_IDX =
        npc_pkg::IDX_W'(npc_pkg::PALETTE_ENTRIES - 1);

    npc_pkg::state_t state_reg, state_next;

    logic [npc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [npc_pkg::IDX_W-1:0] rd_idx_reg;
    logic [7:0]                r_reg, g_reg, b_reg;
    logic [npc_pkg::ERR_W-1:0] best_err_reg;
    logic [npc_pkg::IDX_W-1:0] best_idx_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [npc_pkg::CODE_W-1:0] color_code_reg;

    logic                      accept;
    logic                      start_query;
    logic                      load_out;
    logic                      ram_re;
    npc_pkg::wr_req_t          wr;
    logic [npc_pkg::COLOR_W-1:0] rdata;
    logic [npc_pkg::ERR_W-1:0] err;
    logic                      better;
    logic [npc_pkg::IDX_W:0]   shifted;

    assign accept      = in_valid && !in_stall;
    assign start_query = accept && (mode == npc_pkg::MODE_QUERY);
    assign in_stall    = (state_reg != npc_pkg::S_IDLE);

    // writes are only taken while the scanner is idle, so reads never overlap them
    always_comb
    begin
        wr.en   = accept && (mode == npc_pkg::MODE_WRITE) &&
                  ({2'b00, entry_index} < 9'(npc_pkg::PALETTE_ENTRIES));
        wr.addr = npc_pkg::IDX_W'(entry_index);
        wr.data = entry_color;
    end

    npc_ram #(
        .DEPTH (npc_pkg::PALETTE_ENTRIES),
        .AW    (npc_pkg::IDX_W),
        .WIDTH (npc_pkg::COLOR_W)
    ) u_ram (
        .clk   (clk),
        .wr    (wr),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        err = npc_pkg::ERR_W'(npc_pkg::abs_diff(rdata[23:16], r_reg))
            + npc_pkg::ERR_W'(npc_pkg::abs_diff(rdata[15:8],  g_reg))
            + npc_pkg::ERR_W'(npc_pkg::abs_diff(rdata[7:0],   b_reg));
        better = rd_valid_reg && (err < best_err_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rd_valid_next  = 1'b0;
        ram_re         = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            npc_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (start_query)
                    state_next = npc_pkg::S_SCAN;
            end
            npc_pkg::S_SCAN:
            begin
                ram_re        = 1'b1;
                rd_valid_next = 1'b1;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = npc_pkg::S_DRAIN;
            end
            npc_pkg::S_DRAIN:
            begin
                state_next = npc_pkg::S_FINISH;
            end
            npc_pkg::S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = npc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = npc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npc_pkg::S_IDLE;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign shifted = {best_idx_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (start_query)
        begin
            r_reg        <= npc_pkg::clamp_channel(red);
            g_reg        <= npc_pkg::clamp_channel(green);
            b_reg        <= npc_pkg::clamp_channel(blue);
            best_err_reg <= '1;
            best_idx_reg <= '0;
        end
        else if (better)
        begin
            best_err_reg <= err;
            best_idx_reg <= rd_idx_reg;
        end
        if (load_out)
            color_code_reg <= npc_pkg::CODE_W'(shifted);
    end

    assign out_valid  = out_valid_reg;
    assign color_code = color_code_reg;

    a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> state_reg == npc_pkg::S_IDLE)
        else $error("palette write outside idle");

    a_rd_window: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == npc_pkg::S_SCAN || state_reg == npc_pkg::S_DRAIN))
        else $error("read data returned outside scan");

    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == npc_pkg::S_FINISH |-> best_err_reg <= npc_pkg::ERR_W'(npc_pkg::MAX_ERR))
        else $error("scan finished without a best entry");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("finished query did not raise out_valid");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == npc_pkg::S_SCAN && idx_reg == LAST_IDX) |=> state_reg == npc_pkg::S_DRAIN)
        else $error("scan did not end after last entry");

endmodule

@@ src/npc_ram.sv @@
// npc_ram: single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on npc_pkg for the write request struct.

module npc_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH),
    parameter int WIDTH = 24
) (
    input  logic                  clk,
    input  npc_pkg::wr_req_t      wr,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= WIDTH'(wr.data);
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sim/nearest_palette_color_unit_tb.sv @@
// nearest_palette_color_unit_tb: self-checking bench for the nearest palette color unit.
// Needs npc_pkg and nearest_palette_color_unit; drives palette writes and color queries
// and compares every color_code against a directed code or its own copy of the palette search.
`timescale 1ns / 1ps

module nearest_palette_color_unit_tb;

    localparam int HOLD_OFF_CYCLES = 1000;
    localparam int DRAIN_CYCLES    = npc_pkg::PALETTE_ENTRIES + 16;
    localparam int RANDOM_ITEMS    = 320;
    localparam int NUM_PHASES      = 4;
    localparam int DIRECTED_ROWS   = 22;

    typedef struct packed {
        logic                          mode;
        logic [6:0]                    idx;
        logic [npc_pkg::COLOR_W-1:0]   color;
        logic [npc_pkg::CH_W-1:0]      r;
        logic [npc_pkg::CH_W-1:0]      g;
        logic [npc_pkg::CH_W-1:0]      b;
        logic                          has_code;
        logic [npc_pkg::CODE_W-1:0]    code;
    } palette_request_t;

    // Directed rows run on a palette that is all black except where a row writes.
    localparam palette_request_t DIRECTED [DIRECTED_ROWS] = '{
        // all entries tie, lowest index wins
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd0,    12'd0,    12'd0,    1'b1, 8'd0},
        // negative channels clamp to zero
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'h800,  12'hFFF,  12'h800,  1'b1, 8'd0},
        // write ignores its rgb fields
        '{npc_pkg::MODE_WRITE, 7'd127, 24'hFFFFFF, 12'h7FF,  12'h800,  12'h5A5,  1'b0, 8'd0},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'h7FF,  12'h7FF,  12'h7FF,  1'b1, 8'd254},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd255,  12'd255,  12'd255,  1'b1, 8'd254},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd256,  12'd300,  12'd1000, 1'b1, 8'd254},
        '{npc_pkg::MODE_WRITE, 7'd64,  24'hFFFFFF, 12'd0,    12'd0,    12'd0,    1'b0, 8'd0},
        // white now at 64 and 127, tie goes to 64
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd255,  12'd255,  12'd255,  1'b1, 8'd128},
        '{npc_pkg::MODE_WRITE, 7'd0,   24'h804020, 12'hABC,  12'h123,  12'hFFF,  1'b0, 8'd0},
        // query ignores entry fields
        '{npc_pkg::MODE_QUERY, 7'h7F,  24'hFFFFFF, 12'd128,  12'd64,   12'd32,   1'b1, 8'd0},
        '{npc_pkg::MODE_WRITE, 7'd1,   24'h804020, 12'd0,    12'd0,    12'd0,    1'b0, 8'd0},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd128,  12'd64,   12'd32,   1'b1, 8'd0},
        '{npc_pkg::MODE_WRITE, 7'd0,   24'h000000, 12'd0,    12'd0,    12'd0,    1'b0, 8'd0},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd128,  12'd64,   12'd32,   1'b1, 8'd2},
        '{npc_pkg::MODE_QUERY, 7'd55,  24'h0F0F0F, 12'd127,  12'd128,  12'hFFF,  1'b0, 8'd0},
        '{npc_pkg::MODE_WRITE, 7'd2,   24'h00FF00, 12'd0,    12'd0,    12'd0,    1'b0, 8'd0},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd0,    12'd255,  12'd0,    1'b1, 8'd4},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'd0,    12'd200,  12'd10,   1'b0, 8'd0},
        '{npc_pkg::MODE_WRITE, 7'd100, 24'h123456, 12'd0,    12'd0,    12'd0,    1'b0, 8'd0},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'h012,  12'h034,  12'h056,  1'b1, 8'd200},
        '{npc_pkg::MODE_QUERY, 7'd0,   24'h000000, 12'h013,  12'h033,  12'h057,  1'b0, 8'd0},
        '{npc_pkg::MODE_QUERY, 7'd3,   24'h555555, 12'd60,   12'd250,  12'd90,   1'b0, 8'd0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            mode = npc_pkg::MODE_QUERY;
    logic [6:0]                      entry_index = '0;
    logic [npc_pkg::COLOR_W-1:0]     entry_color = '0;
    logic signed [npc_pkg::CH_W-1:0] red = '0;
    logic signed [npc_pkg::CH_W-1:0] green = '0;
    logic signed [npc_pkg::CH_W-1:0] blue = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [npc_pkg::CODE_W-1:0]      color_code;

    logic [npc_pkg::COLOR_W-1:0]     palette_model [npc_pkg::PALETTE_ENTRIES];
    logic [npc_pkg::CODE_W-1:0]      expected_codes [$];
    logic [npc_pkg::CODE_W-1:0]      oldest_code;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_kicks = 0;
    int hold_kicks_seen = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int codes_checked = 0;
    int queries_sent = 0;
    int writes_sent = 0;

    nearest_palette_color_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_index (entry_index),
        .entry_color (entry_color),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_code  (color_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // signed 12-bit channel to 0..255
    function automatic int clip_to_byte(input logic [npc_pkg::CH_W-1:0] raw);
        int v;
        v = $signed(raw);
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return v;
    endfunction

    // L1 nearest search over the model palette, first minimum wins
    function automatic logic [npc_pkg::CODE_W-1:0] predict_color_code(
        input logic [npc_pkg::CH_W-1:0] r_raw,
        input logic [npc_pkg::CH_W-1:0] g_raw,
        input logic [npc_pkg::CH_W-1:0] b_raw);
        int r, g, b, l1_sum, best_sum, best_idx, dr, dg, db;
        r = clip_to_byte(r_raw);
        g = clip_to_byte(g_raw);
        b = clip_to_byte(b_raw);
        best_sum = 1 << 30;
        best_idx = 0;
        for (int i = 0; i < npc_pkg::PALETTE_ENTRIES; i++)
        begin
            dr = int'(palette_model[i][23:16]) - r;
            dg = int'(palette_model[i][15:8]) - g;
            db = int'(palette_model[i][7:0]) - b;
            l1_sum = (dr < 0 ? -dr : dr) + (dg < 0 ? -dg : dg) + (db < 0 ? -db : db);
            if (l1_sum < best_sum)
            begin
                best_sum = l1_sum;
                best_idx = i;
            end
        end
        return npc_pkg::CODE_W'(best_idx << 1);
    endfunction

    // Offer one request, wait for it to be taken, then update the palette copy
    // or queue the code it must produce.
    task automatic send_request(input palette_request_t req);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid    <= 1'b1;
        mode        <= req.mode;
        entry_index <= req.idx;
        entry_color <= req.color;
        red         <= req.r;
        green       <= req.g;
        blue        <= req.b;
        do
            @(posedge clk);
        while (in_stall);
        if (req.mode == npc_pkg::MODE_WRITE)
        begin
            if (int'(req.idx) < npc_pkg::PALETTE_ENTRIES)
                palette_model[req.idx] = req.color;
            writes_sent++;
        end
        else
        begin
            expected_codes = {expected_codes,
                              (req.has_code ? req.code
                                            : predict_color_code(req.r, req.g, req.b))};
            queries_sent++;
        end
    endtask

    // receiver: random stall, plus a long hold-off on request from the main flow
    always @(posedge clk)
    begin
        if (hold_kicks != hold_kicks_seen)
        begin
            hold_kicks_seen = hold_kicks;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_codes.size() == 0)
            begin
                $error("color_code: no query outstanding, actual %0d", color_code);
                mismatch_count++;
            end
            else
            begin
                oldest_code = expected_codes.pop_front();
                codes_checked++;
                if (color_code !== oldest_code)
                begin
                    $error("color_code: expected %0d, actual %0d", oldest_code, color_code);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        palette_request_t req;
        int k, sel, base, ch;
        int phase_sender [NUM_PHASES];
        int phase_receiver [NUM_PHASES];
        logic [npc_pkg::CH_W-1:0] chan [3];

        phase_sender   = '{0, 72, 0, 11};
        phase_receiver = '{0, 0, 72, 11};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // palette is undefined after reset: clear every entry before any query
        for (int i = 0; i < npc_pkg::PALETTE_ENTRIES; i++)
        begin
            req = '0;
            req.mode = npc_pkg::MODE_WRITE;
            req.idx = 7'(i);
            send_request(req);
        end

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i]);

        // random palette for the random part
        for (int i = 0; i < npc_pkg::PALETTE_ENTRIES; i++)
        begin
            req = '0;
            req.mode = npc_pkg::MODE_WRITE;
            req.idx = 7'(i);
            req.color = npc_pkg::COLOR_W'($urandom);
            req.r = npc_pkg::CH_W'($urandom);
            req.g = npc_pkg::CH_W'($urandom);
            req.b = npc_pkg::CH_W'($urandom);
            send_request(req);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            sender_idle_pct = phase_sender[p];
            receiver_stall_pct = phase_receiver[p];
            // first phase: receiver holds off while the sender keeps offering requests
            if (p == 0)
                hold_kicks++;
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
            begin
                req = '0;
                req.idx = 7'($urandom);
                req.color = npc_pkg::COLOR_W'($urandom);
                if ($urandom_range(99) < 35)
                begin
                    req.mode = npc_pkg::MODE_WRITE;
                    // duplicates of existing entries make ties
                    if ($urandom_range(3) == 0)
                        req.color = palette_model[$urandom_range(npc_pkg::PALETTE_ENTRIES - 1)];
                    req.r = npc_pkg::CH_W'($urandom);
                    req.g = npc_pkg::CH_W'($urandom);
                    req.b = npc_pkg::CH_W'($urandom);
                end
                else
                begin
                    req.mode = npc_pkg::MODE_QUERY;
                    k = $urandom_range(npc_pkg::PALETTE_ENTRIES - 1);
                    for (int c = 0; c < 3; c++)
                    begin
                        sel = $urandom_range(7);
                        base = int'(palette_model[k] >> (16 - 8 * c)) & 'hFF;
                        if (sel == 0)
                            ch = int'($urandom_range(4095));
                        else if (sel == 1)
                            ch = int'($urandom_range(255));
                        else
                            ch = base + int'($urandom_range(8)) - 4;   // near an entry
                        chan[c] = npc_pkg::CH_W'(ch);
                    end
                    req.r = chan[0];
                    req.g = chan[1];
                    req.b = chan[2];
                end
                send_request(req);
            end
        end

        in_valid <= 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_codes.size() != 0)
        begin
            $error("color_code: %0d queries left without a result", expected_codes.size());
            mismatch_count++;
        end

        $display("covered %0d palette writes and %0d color queries, %0d codes compared",
                 writes_sent, queries_sent, codes_checked);
        $display("phases: free flow with a long output hold-off, idle sender, %s",
                 "stalled output, both");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
